// ===== src/pzm_pkg.sv =====
package pzm_pkg;

  localparam int MAX_POLYGONS_DEF = 16;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int NUM_SETS         = 2;

  localparam int X_W   = 32;
  localparam int Y_W   = 31;
  localparam int VTX_W = X_W + Y_W;

  localparam int STORE_DEPTH_DEF = NUM_SETS * MAX_POLYGONS_DEF * MAX_VERTICES_DEF;

  localparam logic [1:0] MODE_VERTEX     = 2'd0;
  localparam logic [1:0] MODE_POINT_CNT  = 2'd1;
  localparam logic [1:0] MODE_POLY_CNT   = 2'd2;
  localparam logic [1:0] MODE_QUERY      = 2'd3;

  typedef struct packed {
    logic load_pt;
    logic load_prev;
    logic load_cur;
    logic shift;
    logic mul_a;
    logic mul_b;
  } edge_op_t;

  typedef struct packed {
    logic up;
    logic down;
    logic pos;
    logic neg;
  } edge_stat_t;

endpackage

// ===== src/pzm_ram.sv =====
module pzm_ram
  import pzm_pkg::*;
#(
  parameter int WIDTH = VTX_W,
  parameter int DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pzm_edge.sv =====
module pzm_edge
  import pzm_pkg::*;
(
  input  logic                    clk,
  input  edge_op_t                op,
  input  logic signed [X_W-1:0]   pt_x,
  input  logic signed [Y_W-1:0]   pt_y,
  input  logic [VTX_W-1:0]        rdata,
  output edge_stat_t              stat
);

  logic signed [X_W-1:0]  px, x0, x1;
  logic signed [Y_W-1:0]  py, y0, y1;
  logic signed [X_W:0]    opx;
  logic signed [Y_W:0]    opy;
  logic signed [X_W+Y_W+1:0] prod, prod_a, prod_b;

  // one shared multiplier, used twice per crossing edge
  always_comb begin
    if (op.mul_a) begin
      opx = (X_W+1)'(x1) - (X_W+1)'(x0);
      opy = (Y_W+1)'(py) - (Y_W+1)'(y0);
    end else begin
      opx = (X_W+1)'(px) - (X_W+1)'(x0);
      opy = (Y_W+1)'(y1) - (Y_W+1)'(y0);
    end
    prod = opx * opy;
  end

  always_ff @(posedge clk) begin
    if (op.load_pt) begin
      px <= pt_x;
      py <= pt_y;
    end
    if (op.load_prev) begin
      x0 <= rdata[X_W-1:0];
      y0 <= rdata[VTX_W-1:X_W];
    end else if (op.shift) begin
      x0 <= x1;
      y0 <= y1;
    end
    if (op.load_cur) begin
      x1 <= rdata[X_W-1:0];
      y1 <= rdata[VTX_W-1:X_W];
    end
    if (op.mul_a) begin
      prod_a <= prod;
    end
    if (op.mul_b) begin
      prod_b <= prod;
    end
  end

  assign stat.up   = (y0 <= py) && (y1 > py);
  assign stat.down = (y0 > py) && (y1 <= py);
  assign stat.pos  = prod_a > prod_b;
  assign stat.neg  = prod_a < prod_b;

endmodule

// ===== src/pzm_seq.sv =====
module pzm_seq
  import pzm_pkg::*;
#(
  parameter int MAX_POLYGONS = MAX_POLYGONS_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int KW = $clog2(MAX_POLYGONS + 1),
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int AW = $clog2(NUM_SETS * MAX_POLYGONS * MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          fix,
  input  logic [NW-1:0] n,
  input  logic [KW-1:0] pcount,
  input  logic          taken,
  input  edge_stat_t    stat,
  output logic          busy,
  output logic          done,
  output logic          home,
  output logic          ferry,
  output logic          set_cur,
  output logic [KW-1:0] k,
  output logic [AW-1:0] rd_addr,
  output edge_op_t      op
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POLY  = 3'd1;
  localparam logic [2:0] S_LOAD0 = 3'd2;
  localparam logic [2:0] S_EDGE  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_MULB  = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state, state_next;
  logic                 set_next;
  logic [KW-1:0]        k_next;
  logic [VW-1:0]        vidx, vidx_next;
  logic signed [NW:0]   wn, wn_next;
  logic                 home_next, ferry_next;
  logic                 adv, set_end, match, last;

  assign last = (NW'(vidx) == n - NW'(1));

  always_comb begin
    state_next = state;
    set_next   = set_cur;
    k_next     = k;
    vidx_next  = vidx;
    wn_next    = wn;
    home_next  = home;
    ferry_next = ferry;
    op         = '0;
    adv        = 1'b0;
    set_end    = 1'b0;
    match      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op.load_pt = 1'b1;
          home_next  = 1'b0;
          ferry_next = 1'b0;
          set_next   = 1'b0;
          k_next     = '0;
          state_next = fix ? S_POLY : S_DONE;
        end
      end
      S_POLY: begin
        if (k >= pcount) begin
          set_end = 1'b1;
        end else if (n < NW'(2)) begin
          k_next = KW'(k + KW'(1));
        end else begin
          vidx_next  = '0;
          wn_next    = '0;
          state_next = S_LOAD0;
        end
      end
      S_LOAD0: begin
        op.load_prev = 1'b1;
        vidx_next    = VW'(1);
        state_next   = S_EDGE;
      end
      S_EDGE: begin
        op.load_cur = 1'b1;
        state_next  = S_TEST;
      end
      S_TEST: begin
        if (stat.up || stat.down) begin
          op.mul_a   = 1'b1;
          state_next = S_MULB;
        end else begin
          adv = 1'b1;
        end
      end
      S_MULB: begin
        op.mul_b   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.up && stat.pos) begin
          wn_next = wn + (NW+1)'(1);
        end else if (stat.down && stat.neg) begin
          wn_next = wn - (NW+1)'(1);
        end
        adv = 1'b1;
      end
      S_DONE: begin
        if (taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (adv) begin
      op.shift = 1'b1;
      if (last) begin
        if (wn_next != '0) begin
          set_end = 1'b1;
          match   = 1'b1;
        end else begin
          k_next     = KW'(k + KW'(1));
          state_next = S_POLY;
        end
      end else begin
        vidx_next  = VW'(vidx + VW'(1));
        state_next = S_EDGE;
      end
    end

    if (set_end) begin
      if (!set_cur) begin
        home_next  = match;
        set_next   = 1'b1;
        k_next     = '0;
        state_next = S_POLY;
      end else begin
        ferry_next = match;
        state_next = S_DONE;
      end
    end
  end

  assign rd_addr = AW'((int'(set_next) * MAX_POLYGONS + int'(k_next)) * MAX_VERTICES
                       + int'(vidx_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    set_cur <= set_next;
    k       <= k_next;
    vidx    <= vidx_next;
    wn      <= wn_next;
    home    <= home_next;
    ferry   <= ferry_next;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== src/polygon_zone_membership_top.sv =====
// Point-in-polygon zone test against two polygon sets (home ports, ferry lanes).
// Input channel (in_valid / in_stall) carries one transaction per command:
// vertex write, polygon point count, set polygon count, or query (mode).
// Writes take effect in the accepting cycle and produce no result.
// A query produces one transaction on the output channel (out_valid /
// out_stall) with the two membership flags and their OR.
// A query walks each set polygon slot by slot; each polygon of two or more points
// loads its first vertex, then reads and tests each edge, with two more multiplier
// steps for an edge that crosses the query latitude; the walk stops at the first
// hit in a set, which also saves that set's closing step.
// The walk is paced by the single vertex RAM read port and the one multiplier
// shared by both cross products.
// A query with fix_valid low returns all flags clear.
// in_stall is high while a query is in progress; writes are taken back to back.
// A finished result sits in the output register; while out_stall is high it
// holds, and a new query may run but waits at its end for the register.
// Reset clears point and polygon counts and the output valid; vertex contents
// are undefined until written.
module polygon_zone_membership_top
  import pzm_pkg::*;
#(
  parameter int MAX_POLYGONS = MAX_POLYGONS_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic                  set_sel,
  input  logic [3:0]            poly_index,
  input  logic [7:0]            vertex_index,
  input  logic signed [X_W-1:0] x_coord,
  input  logic signed [Y_W-1:0] y_coord,
  input  logic [8:0]            count_value,
  input  logic                  fix_valid,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  in_home_port,
  output logic                  in_ferry_lane,
  output logic                  in_special_area
);

  localparam int KW    = $clog2(MAX_POLYGONS + 1);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int IW    = $clog2(NUM_SETS * MAX_POLYGONS);
  localparam int DEPTH = NUM_SETS * MAX_POLYGONS * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  logic [NW-1:0]    point_counts [NUM_SETS * MAX_POLYGONS];
  logic [KW-1:0]    polygon_counts [NUM_SETS];

  logic             accept, start, poly_ok, vert_ok, taken;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [VTX_W-1:0] rdata;
  logic [IW-1:0]    wr_idx, rd_idx;
  logic [NW-1:0]    pc_wr, n;
  logic [KW-1:0]    pk_wr;
  logic             busy, done, home, ferry, set_cur;
  logic [KW-1:0]    k;
  edge_op_t         op;
  edge_stat_t       stat;

  assign accept  = in_valid && !in_stall;
  assign start   = accept && (mode == MODE_QUERY);
  assign poly_ok = int'(poly_index) < MAX_POLYGONS;
  assign vert_ok = int'(vertex_index) < MAX_VERTICES;
  assign in_stall = busy;

  assign we     = accept && (mode == MODE_VERTEX) && poly_ok && vert_ok;
  assign waddr  = AW'((int'(set_sel) * MAX_POLYGONS + int'(poly_index)) * MAX_VERTICES
                      + int'(vertex_index));
  assign wr_idx = IW'(int'(set_sel) * MAX_POLYGONS + int'(poly_index));
  assign rd_idx = IW'(int'(set_cur) * MAX_POLYGONS + int'(k));

  assign pc_wr = (int'(count_value) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_value);
  assign pk_wr = (int'(count_value) > MAX_POLYGONS) ? KW'(MAX_POLYGONS) : KW'(count_value);

  assign n = point_counts[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SETS * MAX_POLYGONS; i++) begin
        point_counts[i] <= '0;
      end
      for (int i = 0; i < NUM_SETS; i++) begin
        polygon_counts[i] <= '0;
      end
    end else begin
      if (accept && (mode == MODE_POINT_CNT) && poly_ok) begin
        point_counts[wr_idx] <= pc_wr;
      end
      if (accept && (mode == MODE_POLY_CNT)) begin
        polygon_counts[set_sel] <= pk_wr;
      end
    end
  end

  pzm_ram #(
    .WIDTH(VTX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({y_coord, x_coord}),
    .raddr(raddr),
    .rdata(rdata)
  );

  pzm_edge u_edge (
    .clk  (clk),
    .op   (op),
    .pt_x (x_coord),
    .pt_y (y_coord),
    .rdata(rdata),
    .stat (stat)
  );

  pzm_seq #(
    .MAX_POLYGONS(MAX_POLYGONS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .fix    (fix_valid),
    .n      (n),
    .pcount (polygon_counts[set_cur]),
    .taken  (taken),
    .stat   (stat),
    .busy   (busy),
    .done   (done),
    .home   (home),
    .ferry  (ferry),
    .set_cur(set_cur),
    .k      (k),
    .rd_addr(raddr),
    .op     (op)
  );

  assign taken = done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (taken) begin
      in_home_port    <= home;
      in_ferry_lane   <= ferry;
      in_special_area <= home || ferry;
    end
  end

endmodule

// ===== src/pzm_checker.sv =====
module pzm_checker
  import pzm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic       in_home_port,
  input logic       in_ferry_lane,
  input logic       in_special_area
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({in_home_port, in_ferry_lane, in_special_area}))
    else $error("result changed while stalled");

  a_or_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_special_area == (in_home_port || in_ferry_lane)))
    else $error("special area flag is not the OR of the zone flags");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_QUERY) |=> in_stall)
    else $error("query transaction did not occupy the block");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind polygon_zone_membership_top pzm_checker u_pzm_checker (.*);
